/* hw/rtl/echo_pulse_trimmed_mean_ranger_core_defines.svh */
// ----------------------------------------------------------------------------
// Echo ranger assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_TRIMMED_MEAN_RANGER_CORE_DEFINES_SVH
`define ECHO_PULSE_TRIMMED_MEAN_RANGER_CORE_DEFINES_SVH

// same-cycle implication
`define EPTMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EPTMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// plain invariant
`define EPTMR_ASSERT_ALW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/eptmr_pkg.sv */
// ----------------------------------------------------------------------------
// Echo ranger package
// Shared constants, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eptmr_pkg;

    localparam int DATA_W           = 16;
    localparam int WINDOW_DEPTH_DEF = 10;
    localparam int MID_COUNT        = 4;
    localparam int MID_SHIFT        = 2;
    localparam int SUM_W            = DATA_W + MID_SHIFT;
    localparam int PROD_W           = 2 * DATA_W;
    localparam int FRAC_BITS        = 8;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ADDEND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8    = 1'b1;

    localparam logic [DATA_W-1:0] WRAP_ADDEND_RST = 16'd7999;
    localparam logic [DATA_W-1:0] SCALE_Q8_RST    = 16'd44;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_MULT,
        ST_STORE,
        ST_COPY,
        ST_SORT,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ld_start;
        logic ld_cap;
        logic calc_width;
        logic calc_prod;
        logic wr_window;
        logic copy;
        logic sort_step;
        logic sort_odd;
        logic calc_sum;
        logic ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/eptmr_ctrl.sv */
// ----------------------------------------------------------------------------
// Echo ranger controller
// Edge tracking, measurement sequencing and sort pass counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eptmr_ctrl #(
    parameter int WINDOW_DEPTH = eptmr_pkg::WINDOW_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire eptmr_pkg::t_dp_status i_status,
    output eptmr_pkg::t_dp_cmd     o_cmd
);
    import eptmr_pkg::*;

    localparam int PASS_W = $clog2(WINDOW_DEPTH);

    t_state              r_state, n_state;
    logic                r_awaiting_fall, n_awaiting_fall;
    logic [PASS_W-1:0]   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_awaiting_fall <= 1'b0;
            r_pass          <= '0;
        end else begin
            r_state         <= n_state;
            r_awaiting_fall <= n_awaiting_fall;
            r_pass          <= n_pass;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_awaiting_fall = r_awaiting_fall;
        n_pass          = r_pass;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!r_awaiting_fall) begin
                        o_cmd.ld_start  = 1'b1;
                        n_awaiting_fall = 1'b1;
                    end else begin
                        o_cmd.ld_cap    = 1'b1;
                        n_awaiting_fall = 1'b0;
                        n_state         = ST_WIDTH;
                    end
                end
            end
            ST_WIDTH: begin
                o_cmd.calc_width = 1'b1;
                n_state          = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.calc_prod = 1'b1;
                n_state         = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.wr_window = 1'b1;
                n_state         = ST_COPY;
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                n_pass     = '0;
                n_state    = ST_SORT;
            end
            ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.sort_odd  = r_pass[0];
                if (r_pass == PASS_W'(WINDOW_DEPTH - 1)) begin
                    n_state = ST_SUM;
                end else begin
                    n_pass = r_pass + 1'b1;
                end
            end
            ST_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/eptmr_dp.sv */
// ----------------------------------------------------------------------------
// Echo ranger datapath
// Width with wrap, Q8.8 scaling, sample ring, odd-even sort, middle mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eptmr_dp #(
    parameter int WINDOW_DEPTH = eptmr_pkg::WINDOW_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [eptmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [eptmr_pkg::DATA_W-1:0]         i_cfg_data,
    input  wire [eptmr_pkg::DATA_W-1:0]         i_capture_value,
    input  wire eptmr_pkg::t_dp_cmd             i_cmd,
    output eptmr_pkg::t_dp_status               o_status,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [eptmr_pkg::DATA_W-1:0]        o_distance_mm,
    output logic [eptmr_pkg::DATA_W-1:0]        o_pulse_ticks
);
    import eptmr_pkg::*;

    localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
    localparam int MID_FIRST = (WINDOW_DEPTH - MID_COUNT) / 2;

    logic [DATA_W-1:0] r_wrap_addend, r_scale_q8;
    logic [DATA_W-1:0] r_start, r_cap, r_width, r_width_ticks;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] r_window [WINDOW_DEPTH];
    logic [DATA_W-1:0] r_sort   [WINDOW_DEPTH];
    logic [DATA_W-1:0] n_sort   [WINDOW_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_distance, r_ticks;

    logic [DATA_W:0]   wrap_sum, wrap_diff;
    logic [DATA_W-1:0] n_width, sample;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_addend <= WRAP_ADDEND_RST;
            r_scale_q8    <= SCALE_Q8_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRAP_ADDEND: r_wrap_addend <= i_cfg_data;
                CFG_SCALE_Q8:    r_scale_q8    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // width with wrap correction, clamped to 0..65535
    always_comb begin
        wrap_sum  = {1'b0, r_wrap_addend} + {1'b0, r_cap};
        wrap_diff = wrap_sum - {1'b0, r_start};
        if (r_cap < r_start) begin
            if (wrap_sum < {1'b0, r_start}) begin
                n_width = '0;
            end else if (wrap_diff[DATA_W]) begin
                n_width = '1;
            end else begin
                n_width = wrap_diff[DATA_W-1:0];
            end
        end else begin
            n_width = r_cap - r_start;
        end
    end

    assign sample = (|r_prod[PROD_W-1:DATA_W+FRAC_BITS]) ? '1
                  : r_prod[DATA_W+FRAC_BITS-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cmd.ld_start) begin
            r_start <= i_capture_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cap) begin
            r_cap <= i_capture_value;
        end
        if (i_cmd.calc_width) begin
            r_width <= n_width;
        end
        if (i_cmd.calc_prod) begin
            r_prod        <= r_width * r_scale_q8;
            r_width_ticks <= r_width;
        end
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_window[i] <= '0;
            end
            r_slot <= '0;
        end else if (i_cmd.wr_window) begin
            r_window[r_slot] <= sample;
            r_slot <= (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    // odd-even transposition step over disjoint neighbor pairs
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            n_sort[i] = r_sort[i];
        end
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            if (((i % 2) == 1) == i_cmd.sort_odd && r_sort[i] > r_sort[i+1]) begin
                n_sort[i]   = r_sort[i+1];
                n_sort[i+1] = r_sort[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_sort[i] <= r_window[i];
            end
        end else if (i_cmd.sort_step) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_sort[i] <= n_sort[i];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < MID_COUNT; i++) begin
            n_sum = n_sum + SUM_W'(r_sort[MID_FIRST + i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.ld_out) begin
            r_distance <= r_sum[SUM_W-1:MID_SHIFT];
            r_ticks    <= r_width_ticks;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_distance_mm     = r_distance;
    assign o_pulse_ticks     = r_ticks;

endmodule

`default_nettype wire

/* hw/rtl/echo_pulse_trimmed_mean_ranger_core.sv */
// ----------------------------------------------------------------------------
// Echo pulse trimmed-mean ranger
// Echo width from alternating edge captures, scaled to mm, filtered by the
// mean of the middle four samples of a sorted window.
//
//   channel   dir  handshake                   payload
//   s_axis    in   i_s_axis_tvalid/o_..tready  capture_value
//   m_axis    out  o_m_axis_tvalid/i_..tready  distance_mm, pulse_ticks
//   cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A rising-edge item is taken while idle. A falling-edge item holds off input
// through the width, scale, store, copy, sort, sum and output states, and its
// result is then loaded into the output register. The odd-even sort runs one
// pass per cycle. Input is taken again once the result is loaded.
// A waiting result stalls only the final load into the output register.
// Synchronous active-low reset clears the window and edge state, restores config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "echo_pulse_trimmed_mean_ranger_core_defines.svh"

module echo_pulse_trimmed_mean_ranger_core #(
    parameter int WINDOW_DEPTH = eptmr_pkg::WINDOW_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire  [15:0]                     i_s_axis_tdata,  // [15:0] capture_value
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,  // [15:0] distance_mm,
                                                             // [31:16] pulse_ticks
    input  wire                             i_cfg_we,
    input  wire  [eptmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [eptmr_pkg::DATA_W-1:0]    i_cfg_data
);
    import eptmr_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [DATA_W-1:0] distance_mm, pulse_ticks;

    eptmr_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eptmr_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_capture_value (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_distance_mm   (distance_mm),
        .o_pulse_ticks   (pulse_ticks)
    );

    assign o_m_axis_tdata = {pulse_ticks, distance_mm};

    `EPTMR_ASSERT_NOW(a_no_result_overwrite, cmd.ld_out, !o_m_axis_tvalid || i_m_axis_tready, "result overwritten while waiting")
    `EPTMR_ASSERT_NXT(a_busy_after_fall, cmd.ld_cap, !o_s_axis_tready, "input taken during measurement")
    `EPTMR_ASSERT_ALW(a_cmd_exclusive, $onehot0({cmd.ld_start, cmd.ld_cap, cmd.wr_window, cmd.sort_step, cmd.ld_out}), "conflicting datapath commands")
    `EPTMR_ASSERT_NOW(a_load_only_on_accept, cmd.ld_start || cmd.ld_cap, i_s_axis_tvalid && o_s_axis_tready, "capture loaded without accept")

endmodule

`default_nettype wire
